// File: src/bce_pkg.sv
// Package: instruction kinds, address modes, payload types and the decode table.
package bce_pkg;

  typedef enum logic [5:0] {
    K_NOP, K_ADC, K_AND, K_ASL, K_BCC, K_BCS, K_BEQ, K_BIT, K_BMI, K_BNE, K_BPL,
    K_BVC, K_BVS, K_CLC, K_CLD, K_CLI, K_CLV, K_CMP, K_CPX, K_CPY, K_DEC, K_DEX,
    K_DEY, K_EOR, K_INC, K_INX, K_INY, K_JMP, K_JSR, K_LDA, K_LDX, K_LDY, K_LSR,
    K_ORA, K_PHA, K_PHP, K_PLA, K_PLP, K_ROL, K_ROR, K_RTS, K_SBC, K_SEC, K_SED,
    K_SEI, K_STA, K_STX, K_STY, K_TAX, K_TAY, K_TSX, K_TXA, K_TXS, K_TYA
  } kind_e;

  typedef enum logic [2:0] {M1, M2, M3, X2, X3} mode_e;

  localparam int unsigned QueueDepth = 2;
  localparam logic [15:0] PageMask = 16'hFF00;
  localparam logic [15:0] LowMask  = 16'h00FF;
  localparam logic [15:0] StackBase = 16'h0100;

  typedef struct packed {
    logic [7:0]        op_code;
    logic [7:0]        operand_data;
    logic [15:0]       effective_addr;
    logic signed [7:0] branch_offset;
    logic              page_crossed;
    logic [7:0]        pull_first;
    logic [7:0]        pull_second;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        last_of_run;
    logic [15:0] next_pc;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic [3:0]  cycle_count;
  } out_item_t;

  // Decoded instruction travelling from front to back.
  typedef struct packed {
    kind_e       kind;
    mode_e       mode;
    logic [3:0]  cyc;
    logic [7:0]  data;
    logic [15:0] ea;
    logic [7:0]  off;
    logic [7:0]  p1;
    logic [7:0]  p2;
  } dec_t;

  typedef struct packed {
    kind_e      kind;
    mode_e      mode;
    logic [3:0] cyc;
  } insn_t;

  function automatic insn_t e(kind_e k, mode_e m, int c);
    e = '{kind: k, mode: m, cyc: 4'(c)};
  endfunction

  function automatic insn_t decode(logic [7:0] op);
    case (op)
      8'h00: decode = e(K_NOP,M2,7); 8'h01: decode = e(K_ORA,M2,6);
      8'h02: decode = e(K_NOP,M1,2); 8'h03: decode = e(K_NOP,M1,8);
      8'h04: decode = e(K_NOP,M1,3); 8'h05: decode = e(K_ORA,M2,3);
      8'h06: decode = e(K_ASL,M2,5); 8'h07: decode = e(K_NOP,M1,5);
      8'h08: decode = e(K_PHP,M1,3); 8'h09: decode = e(K_ORA,M2,2);
      8'h0A: decode = e(K_ASL,M1,2); 8'h0B: decode = e(K_NOP,M1,2);
      8'h0C: decode = e(K_NOP,M1,4); 8'h0D: decode = e(K_ORA,M3,4);
      8'h0E: decode = e(K_ASL,M3,6); 8'h0F: decode = e(K_NOP,M1,6);
      8'h10: decode = e(K_BPL,M2,2); 8'h11: decode = e(K_ORA,X2,5);
      8'h12: decode = e(K_NOP,M1,2); 8'h13: decode = e(K_NOP,M1,8);
      8'h14: decode = e(K_NOP,M1,4); 8'h15: decode = e(K_ORA,M2,4);
      8'h16: decode = e(K_ASL,M2,6); 8'h17: decode = e(K_NOP,M1,6);
      8'h18: decode = e(K_CLC,M1,2); 8'h19: decode = e(K_ORA,X3,4);
      8'h1A: decode = e(K_NOP,M1,2); 8'h1B: decode = e(K_NOP,M1,7);
      8'h1C: decode = e(K_NOP,M1,4); 8'h1D: decode = e(K_ORA,X3,4);
      8'h1E: decode = e(K_ASL,X3,7); 8'h1F: decode = e(K_NOP,M1,7);
      8'h20: decode = e(K_JSR,M3,6); 8'h21: decode = e(K_AND,M2,6);
      8'h22: decode = e(K_NOP,M1,2); 8'h23: decode = e(K_NOP,M1,8);
      8'h24: decode = e(K_BIT,M2,3); 8'h25: decode = e(K_AND,M2,3);
      8'h26: decode = e(K_ROL,M2,5); 8'h27: decode = e(K_NOP,M1,5);
      8'h28: decode = e(K_PLP,M1,4); 8'h29: decode = e(K_AND,M2,2);
      8'h2A: decode = e(K_ROL,M1,2); 8'h2B: decode = e(K_NOP,M1,2);
      8'h2C: decode = e(K_BIT,M3,4); 8'h2D: decode = e(K_AND,M3,4);
      8'h2E: decode = e(K_ROL,M3,6); 8'h2F: decode = e(K_NOP,M1,6);
      8'h30: decode = e(K_BMI,M2,2); 8'h31: decode = e(K_AND,X2,5);
      8'h32: decode = e(K_NOP,M1,2); 8'h33: decode = e(K_NOP,M1,8);
      8'h34: decode = e(K_NOP,M1,4); 8'h35: decode = e(K_AND,M2,4);
      8'h36: decode = e(K_ROL,M2,6); 8'h37: decode = e(K_NOP,M1,6);
      8'h38: decode = e(K_SEC,M1,2); 8'h39: decode = e(K_AND,X3,4);
      8'h3A: decode = e(K_NOP,M1,2); 8'h3B: decode = e(K_NOP,M1,7);
      8'h3C: decode = e(K_NOP,M1,4); 8'h3D: decode = e(K_AND,X3,4);
      8'h3E: decode = e(K_ROL,X3,7); 8'h3F: decode = e(K_NOP,M1,7);
      8'h40: decode = e(K_NOP,M1,6); 8'h41: decode = e(K_EOR,M2,6);
      8'h42: decode = e(K_NOP,M1,2); 8'h43: decode = e(K_NOP,M1,8);
      8'h44: decode = e(K_NOP,M1,3); 8'h45: decode = e(K_EOR,M2,3);
      8'h46: decode = e(K_LSR,M2,5); 8'h47: decode = e(K_NOP,M1,5);
      8'h48: decode = e(K_PHA,M1,3); 8'h49: decode = e(K_EOR,M2,2);
      8'h4A: decode = e(K_LSR,M1,2); 8'h4B: decode = e(K_NOP,M1,2);
      8'h4C: decode = e(K_JMP,M3,3); 8'h4D: decode = e(K_EOR,M3,4);
      8'h4E: decode = e(K_LSR,M3,6); 8'h4F: decode = e(K_NOP,M1,6);
      8'h50: decode = e(K_BVC,M2,2); 8'h51: decode = e(K_EOR,X2,5);
      8'h52: decode = e(K_NOP,M1,2); 8'h53: decode = e(K_NOP,M1,8);
      8'h54: decode = e(K_NOP,M1,4); 8'h55: decode = e(K_EOR,M2,4);
      8'h56: decode = e(K_LSR,M2,6); 8'h57: decode = e(K_NOP,M1,6);
      8'h58: decode = e(K_CLI,M1,2); 8'h59: decode = e(K_EOR,X3,4);
      8'h5A: decode = e(K_NOP,M1,2); 8'h5B: decode = e(K_NOP,M1,7);
      8'h5C: decode = e(K_NOP,M1,4); 8'h5D: decode = e(K_EOR,X3,4);
      8'h5E: decode = e(K_LSR,X3,7); 8'h5F: decode = e(K_NOP,M1,7);
      8'h60: decode = e(K_RTS,M1,6); 8'h61: decode = e(K_ADC,M2,6);
      8'h62: decode = e(K_NOP,M1,2); 8'h63: decode = e(K_NOP,M1,8);
      8'h64: decode = e(K_NOP,M1,3); 8'h65: decode = e(K_ADC,M2,3);
      8'h66: decode = e(K_ROR,M2,5); 8'h67: decode = e(K_NOP,M1,5);
      8'h68: decode = e(K_PLA,M1,4); 8'h69: decode = e(K_ADC,M2,2);
      8'h6A: decode = e(K_ROR,M1,2); 8'h6B: decode = e(K_NOP,M1,2);
      8'h6C: decode = e(K_JMP,M3,5); 8'h6D: decode = e(K_ADC,M3,4);
      8'h6E: decode = e(K_ROR,M3,6); 8'h6F: decode = e(K_NOP,M1,6);
      8'h70: decode = e(K_BVS,M2,2); 8'h71: decode = e(K_ADC,X2,5);
      8'h72: decode = e(K_NOP,M1,2); 8'h73: decode = e(K_NOP,M1,8);
      8'h74: decode = e(K_NOP,M1,4); 8'h75: decode = e(K_ADC,M2,4);
      8'h76: decode = e(K_ROR,M2,6); 8'h77: decode = e(K_NOP,M1,6);
      8'h78: decode = e(K_SEI,M1,2); 8'h79: decode = e(K_ADC,X3,4);
      8'h7A: decode = e(K_NOP,M1,2); 8'h7B: decode = e(K_NOP,M1,7);
      8'h7C: decode = e(K_NOP,M1,4); 8'h7D: decode = e(K_ADC,X3,4);
      8'h7E: decode = e(K_ROR,X3,7); 8'h7F: decode = e(K_NOP,M1,7);
      8'h80: decode = e(K_NOP,M1,2); 8'h81: decode = e(K_STA,M2,6);
      8'h82: decode = e(K_NOP,M1,2); 8'h83: decode = e(K_NOP,M1,6);
      8'h84: decode = e(K_STY,M2,3); 8'h85: decode = e(K_STA,M2,3);
      8'h86: decode = e(K_STX,M2,3); 8'h87: decode = e(K_NOP,M1,3);
      8'h88: decode = e(K_DEY,M1,2); 8'h89: decode = e(K_NOP,M1,2);
      8'h8A: decode = e(K_TXA,M1,2); 8'h8B: decode = e(K_NOP,M1,2);
      8'h8C: decode = e(K_STY,M3,4); 8'h8D: decode = e(K_STA,M3,4);
      8'h8E: decode = e(K_STX,M3,4); 8'h8F: decode = e(K_NOP,M1,4);
      8'h90: decode = e(K_BCC,M2,2); 8'h91: decode = e(K_STA,X2,6);
      8'h92: decode = e(K_NOP,M1,2); 8'h93: decode = e(K_NOP,M1,6);
      8'h94: decode = e(K_STY,M2,4); 8'h95: decode = e(K_STA,M2,4);
      8'h96: decode = e(K_STX,M2,4); 8'h97: decode = e(K_NOP,M1,4);
      8'h98: decode = e(K_TYA,M1,2); 8'h99: decode = e(K_STA,X3,5);
      8'h9A: decode = e(K_TXS,M1,2); 8'h9B: decode = e(K_NOP,M1,5);
      8'h9C: decode = e(K_NOP,M1,5); 8'h9D: decode = e(K_STA,X3,5);
      8'h9E: decode = e(K_NOP,M1,5); 8'h9F: decode = e(K_NOP,M1,5);
      8'hA0: decode = e(K_LDY,M2,2); 8'hA1: decode = e(K_LDA,M2,6);
      8'hA2: decode = e(K_LDX,M2,2); 8'hA3: decode = e(K_NOP,M1,6);
      8'hA4: decode = e(K_LDY,M2,3); 8'hA5: decode = e(K_LDA,M2,3);
      8'hA6: decode = e(K_LDX,M2,3); 8'hA7: decode = e(K_NOP,M1,3);
      8'hA8: decode = e(K_TAY,M1,2); 8'hA9: decode = e(K_LDA,M2,2);
      8'hAA: decode = e(K_TAX,M1,2); 8'hAB: decode = e(K_NOP,M1,2);
      8'hAC: decode = e(K_LDY,M3,4); 8'hAD: decode = e(K_LDA,M3,4);
      8'hAE: decode = e(K_LDX,M3,4); 8'hAF: decode = e(K_NOP,M1,4);
      8'hB0: decode = e(K_BCS,M2,2); 8'hB1: decode = e(K_LDA,X2,5);
      8'hB2: decode = e(K_NOP,M1,2); 8'hB3: decode = e(K_NOP,M1,5);
      8'hB4: decode = e(K_LDY,M2,4); 8'hB5: decode = e(K_LDA,M2,4);
      8'hB6: decode = e(K_LDX,M2,4); 8'hB7: decode = e(K_NOP,M1,4);
      8'hB8: decode = e(K_CLV,M1,2); 8'hB9: decode = e(K_LDA,X3,4);
      8'hBA: decode = e(K_TSX,M1,2); 8'hBB: decode = e(K_NOP,M1,4);
      8'hBC: decode = e(K_LDY,X3,4); 8'hBD: decode = e(K_LDA,X3,4);
      8'hBE: decode = e(K_LDX,X3,4); 8'hBF: decode = e(K_NOP,M1,4);
      8'hC0: decode = e(K_CPY,M2,2); 8'hC1: decode = e(K_CMP,M2,6);
      8'hC2: decode = e(K_NOP,M1,2); 8'hC3: decode = e(K_NOP,M1,8);
      8'hC4: decode = e(K_CPY,M2,3); 8'hC5: decode = e(K_CMP,M2,3);
      8'hC6: decode = e(K_DEC,M2,5); 8'hC7: decode = e(K_NOP,M1,5);
      8'hC8: decode = e(K_INY,M1,2); 8'hC9: decode = e(K_CMP,M2,2);
      8'hCA: decode = e(K_DEX,M1,2); 8'hCB: decode = e(K_NOP,M1,2);
      8'hCC: decode = e(K_CPY,M3,4); 8'hCD: decode = e(K_CMP,M3,4);
      8'hCE: decode = e(K_DEC,M3,6); 8'hCF: decode = e(K_NOP,M1,6);
      8'hD0: decode = e(K_BNE,M2,2); 8'hD1: decode = e(K_CMP,X2,5);
      8'hD2: decode = e(K_NOP,M1,2); 8'hD3: decode = e(K_NOP,M1,8);
      8'hD4: decode = e(K_NOP,M1,4); 8'hD5: decode = e(K_CMP,M2,4);
      8'hD6: decode = e(K_DEC,M2,6); 8'hD7: decode = e(K_NOP,M1,6);
      8'hD8: decode = e(K_CLD,M1,2); 8'hD9: decode = e(K_CMP,X3,4);
      8'hDA: decode = e(K_NOP,M1,2); 8'hDB: decode = e(K_NOP,M1,7);
      8'hDC: decode = e(K_NOP,M1,4); 8'hDD: decode = e(K_CMP,X3,4);
      8'hDE: decode = e(K_DEC,X3,7); 8'hDF: decode = e(K_NOP,M1,7);
      8'hE0: decode = e(K_CPX,M2,2); 8'hE1: decode = e(K_SBC,M2,6);
      8'hE2: decode = e(K_NOP,M1,2); 8'hE3: decode = e(K_NOP,M1,8);
      8'hE4: decode = e(K_CPX,M2,3); 8'hE5: decode = e(K_SBC,M2,3);
      8'hE6: decode = e(K_INC,M2,5); 8'hE7: decode = e(K_NOP,M1,5);
      8'hE8: decode = e(K_INX,M1,2); 8'hE9: decode = e(K_SBC,M2,2);
      8'hEA: decode = e(K_NOP,M1,2); 8'hEB: decode = e(K_NOP,M1,2);
      8'hEC: decode = e(K_CPX,M3,4); 8'hED: decode = e(K_SBC,M3,4);
      8'hEE: decode = e(K_INC,M3,6); 8'hEF: decode = e(K_NOP,M1,6);
      8'hF0: decode = e(K_BEQ,M2,2); 8'hF1: decode = e(K_SBC,X2,5);
      8'hF2: decode = e(K_NOP,M1,2); 8'hF3: decode = e(K_NOP,M1,8);
      8'hF4: decode = e(K_NOP,M1,4); 8'hF5: decode = e(K_SBC,M2,4);
      8'hF6: decode = e(K_INC,M2,6); 8'hF7: decode = e(K_NOP,M1,6);
      8'hF8: decode = e(K_SED,M1,2); 8'hF9: decode = e(K_SBC,X3,4);
      8'hFA: decode = e(K_NOP,M1,2); 8'hFB: decode = e(K_NOP,M1,7);
      8'hFC: decode = e(K_NOP,M1,4); 8'hFD: decode = e(K_SBC,X3,4);
      8'hFE: decode = e(K_INC,X3,7); 8'hFF: decode = e(K_NOP,M1,7);
      default: decode = e(K_NOP,M1,2);
    endcase
  endfunction

endpackage

// File: src/bce_front.sv
// Front end: decode the opcode, add the page penalty, queue decoded items.
module bce_front import bce_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     dec_valid_o,
  input  logic     dec_ready_i,
  output dec_t     dec_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  dec_t              mem_q [Depth];
  logic [AW-1:0]     wp_q, rp_q;
  logic [AW:0]       cnt_q;
  insn_t             ins;
  dec_t              dec;
  logic              push, pop;

  always_comb begin
    ins = decode(in_data_i.op_code);
    dec.kind = ins.kind;
    dec.mode = ins.mode;
    dec.cyc  = ins.cyc;
    if ((ins.mode inside {X2, X3}) && in_data_i.page_crossed &&
        (ins.kind inside {K_ADC, K_AND, K_CMP, K_EOR, K_LDA, K_LDX, K_LDY,
                          K_ORA, K_SBC})) begin
      dec.cyc = ins.cyc + 4'd1;
    end
    dec.data = in_data_i.operand_data;
    dec.ea   = in_data_i.effective_addr;
    dec.off  = in_data_i.branch_offset;
    dec.p1   = in_data_i.pull_first;
    dec.p2   = in_data_i.pull_second;
  end

  assign in_ready_o  = (cnt_q != (AW+1)'(Depth));
  assign dec_valid_o = (cnt_q != '0);
  assign dec_o       = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = dec_valid_o && dec_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
      end
      if (pop) begin
        rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
      end
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// File: src/bce_back.sv
// Back end: execute one decoded instruction, hold architectural state, emit results.
module bce_back import bce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      dec_valid_i,
  output logic      dec_ready_o,
  input  dec_t      dec_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);
  logic [7:0]  a_q, x_q, y_q, sp_q, f_q;
  logic [15:0] pc_q;
  out_item_t   res_q, sec_q;
  logic        val_q, sec_pend_q;

  logic [7:0]  a, x, y, sp, f, v, r, dd;
  logic [15:0] pc, ret, tgt, disp, wa0, wa1;
  logic [7:0]  wd0, wd1;
  logic [1:0]  nw;
  logic [3:0]  cyc;
  logic [8:0]  sum;
  logic        take, is_br;
  logic        free, go;

  function automatic logic [7:0] nz(logic [7:0] fl, logic [7:0] val);
    nz = {val[7], fl[6:2], (val == 8'd0), fl[0]};
  endfunction

  always_comb begin
    a = a_q; x = x_q; y = y_q; sp = sp_q; f = f_q;
    pc = pc_q + ((dec_i.mode == M1) ? 16'd1 :
                 (dec_i.mode inside {M2, X2}) ? 16'd2 : 16'd3);
    cyc = dec_i.cyc;
    nw = 2'd0; wa0 = '0; wa1 = '0; wd0 = '0; wd1 = '0;
    take = 1'b0; is_br = 1'b0;
    v = (dec_i.mode == M1) ? a_q : dec_i.data;
    r = '0;
    ret = pc - 16'd1;
    dd = (dec_i.kind == K_SBC) ? ~dec_i.data : dec_i.data;
    if (dec_i.kind inside {K_CMP, K_CPX, K_CPY}) begin
      dd = ~dec_i.data;
    end
    sum = {1'b0, (dec_i.kind == K_CPX) ? x_q : (dec_i.kind == K_CPY) ? y_q : a_q}
          + {1'b0, dd} + 9'((dec_i.kind inside {K_ADC, K_SBC}) ? f_q[0] : 1'b1);
    case (dec_i.kind)
      K_ADC, K_SBC: begin
        a = sum[7:0];
        f[0] = sum[8];
        f[6] = (~(a_q[7] ^ dd[7])) & (a_q[7] ^ sum[7]);
        f = nz(f, a);
      end
      K_AND: begin a = a_q & dec_i.data; f = nz(f, a); end
      K_ORA: begin a = a_q | dec_i.data; f = nz(f, a); end
      K_EOR: begin a = a_q ^ dec_i.data; f = nz(f, a); end
      K_ASL, K_LSR, K_ROL, K_ROR: begin
        case (dec_i.kind)
          K_ASL:   r = {v[6:0], 1'b0};
          K_ROL:   r = {v[6:0], f_q[0]};
          K_LSR:   r = {1'b0, v[7:1]};
          default: r = {f_q[0], v[7:1]};
        endcase
        f[0] = (dec_i.kind inside {K_ASL, K_ROL}) ? v[7] : v[0];
        f = nz(f, r);
        if (dec_i.mode == M1) begin
          a = r;
        end else begin
          nw = 2'd1; wa0 = dec_i.ea; wd0 = r;
        end
      end
      K_BIT: begin
        f[1] = ((a_q & dec_i.data) == 8'd0);
        f[7] = dec_i.data[7];
        f[6] = dec_i.data[6];
      end
      K_BPL: begin is_br = 1'b1; take = !f_q[7]; end
      K_BMI: begin is_br = 1'b1; take = f_q[7]; end
      K_BVC: begin is_br = 1'b1; take = !f_q[6]; end
      K_BVS: begin is_br = 1'b1; take = f_q[6]; end
      K_BCC: begin is_br = 1'b1; take = !f_q[0]; end
      K_BCS: begin is_br = 1'b1; take = f_q[0]; end
      K_BNE: begin is_br = 1'b1; take = !f_q[1]; end
      K_BEQ: begin is_br = 1'b1; take = f_q[1]; end
      K_CLC: f[0] = 1'b0;
      K_SEC: f[0] = 1'b1;
      K_CLD: f[3] = 1'b0;
      K_SED: f[3] = 1'b1;
      K_CLI: f[2] = 1'b0;
      K_SEI: f[2] = 1'b1;
      K_CLV: f[6] = 1'b0;
      K_CMP, K_CPX, K_CPY: begin f = nz(f, sum[7:0]); f[0] = sum[8]; end
      K_DEC: begin
        r = dec_i.data - 8'd1; f = nz(f, r); nw = 2'd1; wa0 = dec_i.ea; wd0 = r;
      end
      K_INC: begin
        r = dec_i.data + 8'd1; f = nz(f, r); nw = 2'd1; wa0 = dec_i.ea; wd0 = r;
      end
      K_DEX: begin x = x_q - 8'd1; f = nz(f, x); end
      K_DEY: begin y = y_q - 8'd1; f = nz(f, y); end
      K_INX: begin x = x_q + 8'd1; f = nz(f, x); end
      K_INY: begin y = y_q + 8'd1; f = nz(f, y); end
      K_JMP: pc = dec_i.ea;
      K_JSR: begin
        nw = 2'd2;
        wa0 = StackBase | {8'd0, sp_q};         wd0 = ret[15:8];
        wa1 = StackBase | {8'd0, sp_q - 8'd1};  wd1 = ret[7:0];
        sp = sp_q - 8'd2;
        pc = dec_i.ea;
      end
      K_RTS: begin sp = sp_q + 8'd2; pc = {dec_i.p2, dec_i.p1} + 16'd1; end
      K_LDA: begin a = dec_i.data; f = nz(f, a); end
      K_LDX: begin x = dec_i.data; f = nz(f, x); end
      K_LDY: begin y = dec_i.data; f = nz(f, y); end
      K_PHA: begin nw = 2'd1; wa0 = StackBase | {8'd0, sp_q}; wd0 = a_q; sp = sp_q - 8'd1; end
      K_PHP: begin
        nw = 2'd1; wa0 = StackBase | {8'd0, sp_q}; wd0 = f_q | 8'h30; sp = sp_q - 8'd1;
      end
      K_PLA: begin sp = sp_q + 8'd1; a = dec_i.p1; f = nz(f, a); end
      K_PLP: begin sp = sp_q + 8'd1; f = dec_i.p1; end
      K_STA: begin nw = 2'd1; wa0 = dec_i.ea; wd0 = a_q; end
      K_STX: begin nw = 2'd1; wa0 = dec_i.ea; wd0 = x_q; end
      K_STY: begin nw = 2'd1; wa0 = dec_i.ea; wd0 = y_q; end
      K_TAX: begin x = a_q; f = nz(f, x); end
      K_TAY: begin y = a_q; f = nz(f, y); end
      K_TSX: begin x = sp_q; f = nz(f, x); end
      K_TXA: begin a = x_q; f = nz(f, a); end
      K_TYA: begin a = y_q; f = nz(f, a); end
      K_TXS: sp = x_q;
      default: ;
    endcase
    disp = {{8{dec_i.off[7]}}, dec_i.off};
    tgt = pc + disp;
    if (is_br && take) begin
      cyc = cyc + 4'd1;
      if ((tgt & PageMask) != (pc & PageMask)) begin
        cyc = cyc + 4'd1;
      end
      pc = tgt;
    end
    f = f & 8'hCF;
  end

  // Accept a new instruction when the output slot frees this cycle.
  assign free        = !sec_pend_q && (!val_q || out_ready_i);
  assign dec_ready_o = free;
  assign go          = dec_valid_i && free;
  assign out_valid_o = val_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i) begin
    if (go) begin
      res_q <= '{write_valid: (nw != 2'd0), write_addr: wa0, write_data: wd0,
                 last_of_run: (nw != 2'd2), next_pc: pc, acc_out: a, x_out: x,
                 y_out: y, sp_out: sp, status_out: f | 8'h20, cycle_count: cyc};
      sec_q <= '{write_valid: 1'b1, write_addr: wa1, write_data: wd1,
                 last_of_run: 1'b1, next_pc: pc, acc_out: a, x_out: x,
                 y_out: y, sp_out: sp, status_out: f | 8'h20, cycle_count: cyc};
    end else if (sec_pend_q && out_ready_i) begin
      res_q <= sec_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; x_q <= '0; y_q <= '0; sp_q <= 8'hFD; pc_q <= '0; f_q <= 8'h04;
      val_q <= 1'b0; sec_pend_q <= 1'b0;
    end else begin
      if (go) begin
        a_q <= a; x_q <= x; y_q <= y; sp_q <= sp; pc_q <= pc; f_q <= f;
        val_q <= 1'b1;
        sec_pend_q <= (nw == 2'd2);
      end else if (out_ready_i) begin
        val_q <= sec_pend_q;
        sec_pend_q <= 1'b0;
      end
    end
  end
endmodule

// File: src/byte_cpu_execute_unit.sv
// Top level of the 8-bit CPU execute unit: decode front end, queue, execute back end.
//
// Usage:
//   in channel (in_valid_i / in_ready_o / in_data_i) carries one instruction
//   per transfer: opcode, operand byte, effective address, branch offset,
//   page-cross mark and the two pulled stack bytes.
//   out channel (out_valid_o / out_ready_i / out_data_o) carries one result
//   per transfer; JSR gives two (high then low return byte pushed), every
//   other instruction gives one, and last_of_run marks the final one.
// Flow: an instruction enters the decode queue on its transfer, runs in the back
//   end when the back end is free, and its result is registered for output.
// Throughput: one instruction per cycle while the receiver keeps up; JSR
//   holds the back end until its second result, the low pushed byte, shows. The single
//   output register paces the back end.
// Reset: A, X, Y clear, SP is 0xFD, PC is 0, flags hold only I; the queue
//   empties and no result is shown.
// Stall: when out_ready_i is low the result holds, the back end stops and
//   the front queue takes up to two more instructions before in_ready_o drops.
module byte_cpu_execute_unit import bce_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);
  logic dec_valid, dec_ready;
  dec_t dec;

  bce_front #(.Depth(QDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .dec_valid_o(dec_valid), .dec_ready_i(dec_ready), .dec_o(dec)
  );

  bce_back u_back (
    .clk_i, .rst_ni,
    .dec_valid_i(dec_valid), .dec_ready_o(dec_ready), .dec_i(dec),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule

// File: tb/byte_cpu_execute_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the execute unit: predicts each instruction's results and compares them.
module byte_cpu_execute_unit_checker import bce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam logic [7:0] FlagC = 8'h01;
  localparam logic [7:0] FlagZ = 8'h02;
  localparam logic [7:0] FlagI = 8'h04;
  localparam logic [7:0] FlagD = 8'h08;
  localparam logic [7:0] FlagV = 8'h40;
  localparam logic [7:0] FlagN = 8'h80;

  logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
  logic [15:0] cpu_pc;
  out_item_t   expected_results[$];

  assign pending_o = expected_results.size();

  function automatic logic [7:0] with_nz(logic [7:0] f, logic [7:0] v);
    with_nz = (f & ~(FlagN | FlagZ)) | (v & FlagN) | ((v == 8'h00) ? FlagZ : 8'h00);
  endfunction

  function automatic logic [7:0] with_bit(logic [7:0] f, logic [7:0] b, logic on);
    with_bit = on ? (f | b) : (f & ~b);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Execute one instruction on the shadow registers and queue its results.
  task automatic execute_instruction(in_item_t it);
    insn_t       dec;
    logic [7:0]  a, x, y, sp, f, d, v, r;
    logic [15:0] pc, ret, tgt;
    logic [15:0] wa[2];
    logic [7:0]  wd[2];
    logic [8:0]  sum;
    logic [7:0]  addend;
    int          nw, n, cyc;
    logic        take, is_br;
    out_item_t   res;
    dec = decode(it.op_code);
    a = cpu_a; x = cpu_x; y = cpu_y; sp = cpu_sp; f = cpu_p; d = it.operand_data;
    pc = cpu_pc + ((dec.mode == M1) ? 16'd1 : (dec.mode == M2 || dec.mode == X2) ? 16'd2 : 16'd3);
    cyc = dec.cyc; nw = 0; take = 0; is_br = 0;
    wa[0] = '0; wa[1] = '0; wd[0] = '0; wd[1] = '0;
    if (dec.kind inside {K_ADC, K_AND, K_CMP, K_EOR, K_LDA, K_LDX, K_LDY, K_ORA, K_SBC} &&
        dec.mode inside {X2, X3} && it.page_crossed) cyc++;
    case (dec.kind)
      K_ADC, K_SBC: begin
        addend = (dec.kind == K_SBC) ? ~d : d;
        sum = {1'b0, a} + {1'b0, addend} + {8'd0, f[0]};
        r = sum[7:0];
        f = with_bit(f, FlagC, sum[8]);
        f = with_bit(f, FlagV, (~(a ^ addend) & (a ^ r) & 8'h80) != 0);
        f = with_nz(f, r);
        a = r;
      end
      K_AND: begin a = a & d; f = with_nz(f, a); end
      K_ORA: begin a = a | d; f = with_nz(f, a); end
      K_EOR: begin a = a ^ d; f = with_nz(f, a); end
      K_ASL, K_LSR, K_ROL, K_ROR: begin
        v = (dec.mode == M1) ? a : d;
        case (dec.kind)
          K_ASL:   r = v << 1;
          K_ROL:   r = {v[6:0], f[0]};
          K_LSR:   r = v >> 1;
          default: r = {f[0], v[7:1]};
        endcase
        f = with_bit(f, FlagC, (dec.kind inside {K_ASL, K_ROL}) ? v[7] : v[0]);
        f = with_nz(f, r);
        if (dec.mode == M1) a = r;
        else begin wa[nw] = it.effective_addr; wd[nw] = r; nw++; end
      end
      K_BIT: begin
        f = with_bit(f, FlagZ, (a & d) == 0);
        f = (f & ~(FlagN | FlagV)) | (d & (FlagN | FlagV));
      end
      K_BPL: begin is_br = 1; take = !f[7]; end
      K_BMI: begin is_br = 1; take = f[7]; end
      K_BVC: begin is_br = 1; take = !f[6]; end
      K_BVS: begin is_br = 1; take = f[6]; end
      K_BCC: begin is_br = 1; take = !f[0]; end
      K_BCS: begin is_br = 1; take = f[0]; end
      K_BNE: begin is_br = 1; take = !f[1]; end
      K_BEQ: begin is_br = 1; take = f[1]; end
      K_CLC: f = f & ~FlagC;
      K_SEC: f = f | FlagC;
      K_CLD: f = f & ~FlagD;
      K_SED: f = f | FlagD;
      K_CLI: f = f & ~FlagI;
      K_SEI: f = f | FlagI;
      K_CLV: f = f & ~FlagV;
      K_CMP, K_CPX, K_CPY: begin
        v = (dec.kind == K_CMP) ? a : (dec.kind == K_CPX) ? x : y;
        f = with_nz(f, v - d);
        f = with_bit(f, FlagC, v >= d);
      end
      K_DEC, K_INC: begin
        v = (dec.kind == K_DEC) ? d - 8'd1 : d + 8'd1;
        f = with_nz(f, v);
        wa[nw] = it.effective_addr; wd[nw] = v; nw++;
      end
      K_DEX: begin x = x - 8'd1; f = with_nz(f, x); end
      K_DEY: begin y = y - 8'd1; f = with_nz(f, y); end
      K_INX: begin x = x + 8'd1; f = with_nz(f, x); end
      K_INY: begin y = y + 8'd1; f = with_nz(f, y); end
      K_JMP: pc = it.effective_addr;
      K_JSR: begin
        ret = pc - 16'd1;
        wa[0] = StackBase | {8'd0, sp}; wd[0] = ret[15:8]; sp = sp - 8'd1;
        wa[1] = StackBase | {8'd0, sp}; wd[1] = ret[7:0]; sp = sp - 8'd1;
        nw = 2;
        pc = it.effective_addr;
      end
      K_RTS: begin sp = sp + 8'd2; pc = {it.pull_second, it.pull_first} + 16'd1; end
      K_LDA: begin a = d; f = with_nz(f, a); end
      K_LDX: begin x = d; f = with_nz(f, x); end
      K_LDY: begin y = d; f = with_nz(f, y); end
      K_PHA: begin wa[0] = StackBase | {8'd0, sp}; wd[0] = a; nw = 1; sp = sp - 8'd1; end
      K_PHP: begin
        wa[0] = StackBase | {8'd0, sp}; wd[0] = f | 8'h30; nw = 1; sp = sp - 8'd1;
      end
      K_PLA: begin sp = sp + 8'd1; a = it.pull_first; f = with_nz(f, a); end
      K_PLP: begin sp = sp + 8'd1; f = it.pull_first & 8'hCF; end
      K_STA: begin wa[0] = it.effective_addr; wd[0] = a; nw = 1; end
      K_STX: begin wa[0] = it.effective_addr; wd[0] = x; nw = 1; end
      K_STY: begin wa[0] = it.effective_addr; wd[0] = y; nw = 1; end
      K_TAX: begin x = a; f = with_nz(f, x); end
      K_TAY: begin y = a; f = with_nz(f, y); end
      K_TSX: begin x = sp; f = with_nz(f, x); end
      K_TXA: begin a = x; f = with_nz(f, a); end
      K_TYA: begin a = y; f = with_nz(f, a); end
      K_TXS: sp = x;
      default: ;
    endcase
    if (is_br && take) begin
      tgt = pc + {{8{it.branch_offset[7]}}, it.branch_offset};
      cyc++;
      if ((tgt & PageMask) != (pc & PageMask)) cyc++;
      pc = tgt;
    end
    cpu_a = a; cpu_x = x; cpu_y = y; cpu_sp = sp; cpu_p = f & 8'hCF; cpu_pc = pc;
    n = (nw > 0) ? nw : 1;
    for (int k = 0; k < n; k++) begin
      res.write_valid = nw > 0;
      res.write_addr  = (nw > 0) ? wa[k] : 16'h0;
      res.write_data  = (nw > 0) ? wd[k] : 8'h0;
      res.last_of_run = (k == n - 1);
      res.next_pc     = pc;
      res.acc_out     = a;
      res.x_out       = x;
      res.y_out       = y;
      res.sp_out      = sp;
      res.status_out  = cpu_p | 8'h20;
      res.cycle_count = 4'(cyc);
      expected_results.push_back(res);
    end
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $display("[%0t] result with nothing expected: %h", $realtime, got);
      fail_count_o++;
      return;
    end
    want = expected_results.pop_front();
    if (got.write_valid !== want.write_valid)
      report_mismatch("write_valid", got.write_valid, want.write_valid);
    if (got.write_addr !== want.write_addr)
      report_mismatch("write_addr", got.write_addr, want.write_addr);
    if (got.write_data !== want.write_data)
      report_mismatch("write_data", got.write_data, want.write_data);
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
    if (got.next_pc !== want.next_pc) report_mismatch("next_pc", got.next_pc, want.next_pc);
    if (got.acc_out !== want.acc_out) report_mismatch("acc_out", got.acc_out, want.acc_out);
    if (got.x_out !== want.x_out) report_mismatch("x_out", got.x_out, want.x_out);
    if (got.y_out !== want.y_out) report_mismatch("y_out", got.y_out, want.y_out);
    if (got.sp_out !== want.sp_out) report_mismatch("sp_out", got.sp_out, want.sp_out);
    if (got.status_out !== want.status_out)
      report_mismatch("status_out", got.status_out, want.status_out);
    if (got.cycle_count !== want.cycle_count)
      report_mismatch("cycle_count", got.cycle_count, want.cycle_count);
  endtask

  initial begin
    fail_count_o = 0;
    cpu_a = '0; cpu_x = '0; cpu_y = '0; cpu_sp = 8'hFD; cpu_pc = '0; cpu_p = FlagI;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) execute_instruction(in_data_i);
      if (out_valid_i && out_ready_i) compare_result(out_data_i);
    end
  end

endmodule

// File: tb/byte_cpu_execute_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the execute unit: clock, reset, instruction stimulus and verdict.
module byte_cpu_execute_unit_test;
  import bce_pkg::*;

  localparam int RandomCount = 400;
  localparam int CycleLimit  = 200000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  logic      quiet = 1'b0; // set near the end: no idling on either side

  byte_cpu_execute_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  byte_cpu_execute_unit_checker checker_inst (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop on a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: drop ready in random bursts, change only at the falling edge.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Present one instruction and hold it until the transfer; maybe idle first.
  task automatic send_instruction(in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic in_item_t random_fields(logic [7:0] op);
    in_item_t it;
    it.op_code        = op;
    it.operand_data   = 8'($urandom);
    it.effective_addr = 16'($urandom);
    it.branch_offset  = 8'($urandom);
    it.page_crossed   = 1'($urandom_range(0, 1));
    it.pull_first     = 8'($urandom);
    it.pull_second    = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_item(logic [7:0] op, logic [7:0] d, logic [15:0] ea,
                                         logic [7:0] off, logic pc_mark,
                                         logic [7:0] p1, logic [7:0] p2);
    make_item = '{op, d, ea, off, pc_mark, p1, p2};
  endfunction

  // Bias toward documented opcodes, branches and stack ops; some undocumented noise.
  function automatic logic [7:0] pick_opcode();
    logic [7:0] op;
    case ($urandom_range(0, 9))
      0: op = 8'($urandom);
      1, 2: op = {3'($urandom), 5'h10};  // branches
      3: begin
        case ($urandom_range(0, 5))
          0: op = 8'h20; 1: op = 8'h60; 2: op = 8'h48;
          3: op = 8'h68; 4: op = 8'h08; default: op = 8'h28;
        endcase
      end
      default: begin
        do op = 8'($urandom); while (decode(op).kind == K_NOP);
      end
    endcase
    return op;
  endfunction

  initial begin
    in_item_t it;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, carry/overflow, compare sign, flags stack, JSR/RTS wrap, branches.
    send_instruction(make_item(8'hA9, 8'h7F, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // LDA #7F
    send_instruction(make_item(8'h69, 8'h01, 16'hFFFF, 8'h7F, 1, 8'hFF, 8'hFF)); // ADC ovf
    send_instruction(make_item(8'hE9, 8'hFF, 16'h0000, 8'h80, 0, 8'h00, 8'h00)); // SBC
    send_instruction(make_item(8'hC9, 8'h80, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // CMP
    send_instruction(make_item(8'h7D, 8'hFF, 16'h12FF, 8'h00, 1, 8'h00, 8'h00)); // ADC abs,X pg
    send_instruction(make_item(8'hB1, 8'h00, 16'h0000, 8'h00, 1, 8'h00, 8'h00)); // LDA (zp),Y
    send_instruction(make_item(8'h9D, 8'h00, 16'hFFFF, 8'h00, 1, 8'h00, 8'h00)); // STA no pen
    send_instruction(make_item(8'h08, 8'h00, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // PHP
    send_instruction(make_item(8'h28, 8'h00, 16'h0000, 8'h00, 0, 8'hFF, 8'h00)); // PLP all
    send_instruction(make_item(8'hF8, 8'h00, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // SED
    send_instruction(make_item(8'h69, 8'h09, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // binary ADC
    send_instruction(make_item(8'hD8, 8'h00, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // CLD
    send_instruction(make_item(8'hA2, 8'h00, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // LDX #0
    send_instruction(make_item(8'h9A, 8'h00, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // TXS: SP=0
    send_instruction(make_item(8'h20, 8'h00, 16'hFFFE, 8'h00, 0, 8'h00, 8'h00)); // JSR wrap
    send_instruction(make_item(8'h60, 8'h00, 16'h0000, 8'h00, 0, 8'hFF, 8'hFF)); // RTS wrap
    send_instruction(make_item(8'h68, 8'h00, 16'h0000, 8'h00, 0, 8'h80, 8'h00)); // PLA
    send_instruction(make_item(8'h30, 8'h00, 16'h0000, 8'h80, 0, 8'h00, 8'h00)); // BMI back
    send_instruction(make_item(8'h10, 8'h00, 16'h0000, 8'h7F, 0, 8'h00, 8'h00)); // BPL not
    send_instruction(make_item(8'h38, 8'h00, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // SEC
    send_instruction(make_item(8'hB0, 8'h00, 16'h0000, 8'h7F, 0, 8'h00, 8'h00)); // BCS fwd
    send_instruction(make_item(8'h00, 8'h00, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // BRK
    send_instruction(make_item(8'h40, 8'h00, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // RTI
    send_instruction(make_item(8'hFF, 8'h00, 16'h0000, 8'h00, 0, 8'h00, 8'h00)); // undoc

    // Hold off until every expected result is back before the random part.
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < RandomCount; i++) begin
      if (i == RandomCount - 60) quiet = 1'b1;
      it = random_fields(pick_opcode());
      send_instruction(it);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
